@@ hw/rtl/mcwg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcwg_pkg
// Shared types and codes of the multi-client watchdog gate: transaction
// payloads, command and status codes, register map constants.
// ----------------------------------------------------------------------------
package mcwg_pkg;

	localparam int KEY_W    = 16;
	localparam int TICK_W   = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_TIMEOUT_ADDR = 3'd0;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

	// commands
	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FEED     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FEED_ALL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ALREADY = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_STALE   = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [KEY_W-1:0]  module_key;
		logic [TICK_W-1:0] now;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                hw_kick;
		logic [SLOT_W-1:0]   slot;
	} out_t;

	// one stamp memory word: last feed time and fed flag
	typedef struct packed {
		logic [TICK_W-1:0] stamp;
		logic              fed;
	} stamp_word_t;

endpackage
`default_nettype wire

@@ hw/rtl/mcwg_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcwg_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mcwg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic      [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/multi_client_watchdog_gate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_client_watchdog_gate
// Client table that gates the kick of a hardware watchdog.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is one command (register a key, feed
// a key, feed all, clear) and returns exactly one result. The client table
// sits in two small RAMs (keys, and stamp plus fed flag) that a sequencer
// walks one slot per cycle through a single compare unit. Register and feed
// do a key lookup (one RAM read per cycle, with registered read data); feed
// all does a freshness check over the registered clients and, when it kicks,
// clears every fed flag through the single RAM write port. The input is not
// ready while a command is being worked on. The timeout register sits at
// APB address 0; a value of zero acts as one tick.
// ----------------------------------------------------------------------------
module multi_client_watchdog_gate #(
	parameter int MAX_MODULES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire mcwg_pkg::in_t                 in_data,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output mcwg_pkg::out_t                     out_data,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mcwg_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mcwg_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mcwg_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);
	import mcwg_pkg::*;

	localparam int IW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
	localparam int CW = $clog2(MAX_MODULES + 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_MODULES);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [TICK_W-1:0] timeout_q;
	logic [TICK_W-1:0] limit_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [IW-1:0]     idx_s1;
	logic              valid_s1;
	in_t               cmd_q;
	out_t              res_q;
	out_t              out_q;
	logic              out_valid_q;

	// RAM ports
	logic              key_we;
	logic [IW-1:0]     key_waddr;
	logic [KEY_W-1:0]  key_rdata;
	logic              stamp_we;
	logic [IW-1:0]     stamp_waddr;
	stamp_word_t       stamp_wdata;
	stamp_word_t       stamp_rdata;

	// compare unit and scan control
	logic              accept;
	logic              issue;
	logic              advance;
	logic              last_s1;
	logic              key_hit;
	logic [TICK_W-1:0] elapsed;
	logic              stale;
	logic              scan_found;
	logic              scan_miss;
	logic              check_stale;
	logic              check_pass;
	logic              sweep_last;
	logic              out_free;

	// --- APB configuration ---------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT_ADDR[2])) begin
			timeout_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TIMEOUT_ADDR[2]) begin
			prdata = timeout_q;
		end
	end

	// --- entry storage -------------------------------------------------------
	mcwg_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_MODULES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (cmd_q.module_key),
		.raddr (idx_q[IW-1:0]),
		.rdata (key_rdata)
	);

	mcwg_ram #(
		.WIDTH ($bits(stamp_word_t)),
		.DEPTH (MAX_MODULES)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (stamp_wdata),
		.raddr (idx_q[IW-1:0]),
		.rdata (stamp_rdata)
	);

	// --- shared compare unit -------------------------------------------------
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign issue    = (idx_q < count_q);
	assign last_s1  = ((CW'(idx_s1) + CW'(1)) == count_q);
	assign key_hit  = (key_rdata == cmd_q.module_key);
	assign elapsed  = cmd_q.now - stamp_rdata.stamp;
	assign stale    = !stamp_rdata.fed || (elapsed > limit_q);

	assign scan_found  = valid_s1 && key_hit;
	assign scan_miss   = (count_q == '0) || (valid_s1 && !key_hit && last_s1);
	assign check_stale = valid_s1 && stale;
	assign check_pass  = (count_q == '0) || (valid_s1 && !stale && last_s1);
	assign sweep_last  = ((idx_q + CW'(1)) == count_q);

	// walk goes on to the next slot
	assign advance = (state_q == S_SCAN && !scan_found && !scan_miss) ||
	                 (state_q == S_CHECK && !check_stale && !check_pass);

	// --- RAM write control ---------------------------------------------------
	always_comb begin
		key_we      = 1'b0;
		key_waddr   = count_q[IW-1:0];
		stamp_we    = 1'b0;
		stamp_waddr = idx_s1;
		stamp_wdata = '0;
		case (state_q)
			S_SCAN: begin
				if (scan_found) begin
					if (cmd_q.cmd == CMD_FEED) begin
						stamp_we    = 1'b1;
						stamp_wdata = '{stamp: cmd_q.now, fed: 1'b1};
					end
				end else if (scan_miss && cmd_q.cmd == CMD_REGISTER) begin
					key_we      = 1'b1;
					stamp_we    = 1'b1;
					stamp_waddr = count_q[IW-1:0];
				end
			end
			S_SWEEP: begin
				stamp_we    = 1'b1;
				stamp_waddr = idx_q[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	// --- sequencer -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= advance && issue;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						case (in_data.cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							CMD_REGISTER: begin
								state_q <= (count_q == MAX_COUNT) ? S_DONE : S_SCAN;
							end
							CMD_FEED: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_CHECK;
							end
						endcase
					end
				end
				S_SCAN, S_CHECK: begin
					if ((state_q == S_SCAN && (scan_found || scan_miss)) ||
					    (state_q == S_CHECK && check_stale)) begin
						state_q <= S_DONE;
						if (state_q == S_SCAN && scan_miss &&
						    cmd_q.cmd == CMD_REGISTER && !scan_found) begin
							count_q <= count_q + CW'(1);
						end
					end else if (state_q == S_CHECK && check_pass) begin
						idx_q   <= '0;
						state_q <= (count_q == '0) ? S_DONE : S_SWEEP;
					end else if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SWEEP: begin
					if (sweep_last) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// --- payload registers ---------------------------------------------------
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q   <= in_data;
					limit_q <= (timeout_q == '0) ? TICK_W'(1) : timeout_q;
					res_q   <= '{status: (in_data.cmd == CMD_REGISTER && count_q == MAX_COUNT)
					                     ? STAT_FULL : STAT_OK,
					             hw_kick: 1'b0, slot: '0};
				end
			end
			S_SCAN: begin
				if (scan_found) begin
					if (cmd_q.cmd == CMD_FEED) begin
						res_q.slot <= SLOT_W'(idx_s1);
					end else begin
						res_q.status <= STAT_ALREADY;
					end
				end else if (scan_miss) begin
					if (cmd_q.cmd == CMD_REGISTER) begin
						res_q.slot <= SLOT_W'(count_q);
					end else begin
						res_q.status <= STAT_UNKNOWN;
					end
				end
			end
			S_CHECK: begin
				if (check_stale) begin
					res_q.status <= STAT_STALE;
					res_q.slot   <= SLOT_W'(idx_s1);
				end else if (check_pass) begin
					res_q.hw_kick <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// --- assertions ----------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_COUNT)
		else $error("entry count beyond table size");

	a_kick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hw_kick) |-> (out_data.status == STAT_OK))
		else $error("kick with non-ok status");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after accepting a command");

	a_error_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == STAT_FULL || out_data.status == STAT_ALREADY ||
		               out_data.status == STAT_UNKNOWN)) |-> (out_data.slot == '0))
		else $error("nonzero slot on error result");

endmodule
`default_nettype wire
